// ===== sv/fasta_fastq_record_parser_assert.svh =====
// Assertion macros shared by the record parser modules.
`ifndef FASTA_FASTQ_RECORD_PARSER_ASSERT_SVH
`define FASTA_FASTQ_RECORD_PARSER_ASSERT_SVH

// Check a property at every rising clock edge outside reset.
`define FFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check a property that follows from a trigger, outside reset.
`define FFP_ASSERT_IMP(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

// ===== sv/ffp_pkg.sv =====
// Types, codes and helpers shared by the record parser modules.
package ffp_pkg;

  // Character codes
  localparam logic [7:0] ChrGt    = 8'h3E;
  localparam logic [7:0] ChrAt    = 8'h40;
  localparam logic [7:0] ChrPlus  = 8'h2B;
  localparam logic [7:0] ChrCr    = 8'h0D;
  localparam logic [7:0] ChrTab   = 8'h09;
  localparam logic [7:0] ChrLf    = 8'h0A;
  localparam logic [7:0] ChrSpace = 8'h20;

  // Format codes
  localparam logic [1:0] FmtUnknown = 2'd0;
  localparam logic [1:0] FmtFasta   = 2'd1;
  localparam logic [1:0] FmtFastq   = 2'd2;

  // Field kind codes
  localparam logic [2:0] KindName    = 3'd0;
  localparam logic [2:0] KindComment = 3'd1;
  localparam logic [2:0] KindSeq     = 3'd2;
  localparam logic [2:0] KindQual    = 3'd3;
  localparam logic [2:0] KindEnd     = 3'd4;

  localparam int unsigned MaxResults = 3;

  // All results caused by one input byte, slot 0 first
  typedef struct packed {
    logic [1:0]                      count;
    logic [MaxResults-1:0][7:0]      chars;
    logic [MaxResults-1:0][2:0]      kinds;
  } ffp_bundle_t;

  // Append one result to a bundle; a full bundle is left as it is
  function automatic ffp_bundle_t ffp_put(ffp_bundle_t b, logic [7:0] ch, logic [2:0] kind);
    ffp_bundle_t r;
    r = b;
    if (r.count != 2'd3) begin
      r.chars[r.count] = ch;
      r.kinds[r.count] = kind;
      r.count          = r.count + 2'd1;
    end
    return r;
  endfunction

endpackage

// ===== sv/fasta_fastq_record_parser.sv =====
// Top level of the FASTA / FASTQ record parser.
//
// Input stream: one text byte per item on s_axis (tdata = byte, tlast marks
// the final byte of the stream and closes any open record). Output stream:
// one tagged byte per item on m_axis (tdata = byte, or zero for a record end;
// tuser = field kind: name, comment, sequence, quality, record end; tlast is
// high on the last result caused by one input byte). A byte causes zero to
// three results.
// The front end decides all results of a byte in the cycle it is accepted
// and writes them as one bundle into a QueueDepth-entry queue; the back end
// hands them out one per cycle while the receiver is ready, once the bundle
// is registered in the queue. One byte per cycle is taken while bytes give
// at most one result each and the receiver is ready; the output port sets
// the rate when bytes give more. s_axis_tready falls only when the queue is
// full, so a stalled receiver is absorbed by QueueDepth bundles before input
// stops. Reset clears the parse state, empties the queue and sets the format
// to auto-detect. cfg_we_i writes the format (0 auto, 1 FASTA, 2 FASTQ). The
// user must use it only while the block is idle; the block does not check.
module fasta_fastq_record_parser import ffp_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,      // format_mode
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,     // [7:0] in_char
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,     // [7:0] out_char
  output logic [2:0] m_axis_tuser,     // [2:0] field_kind
  output logic       m_axis_tlast
);

  logic [1:0]  fmt_mode_q;
  logic        push, pop, full, empty;
  ffp_bundle_t push_bundle, head_bundle;

  // Hold the format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_mode_q <= FmtUnknown;
    end else if (cfg_we_i) begin
      fmt_mode_q <= cfg_wdata_i;
    end
  end

  ffp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fmt_mode_i (fmt_mode_q),
    .in_valid_i (s_axis_tvalid),
    .in_char_i  (s_axis_tdata),
    .in_eoi_i   (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .full_i     (full),
    .push_o     (push),
    .bundle_o   (push_bundle)
  );

  ffp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_bundle),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head_bundle)
  );

  ffp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head_bundle),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ===== sv/ffp_front.sv =====
// Front end: classifies each input byte and builds the bundle of results it causes.
module ffp_front import ffp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        fmt_mode_i,
  input  logic              in_valid_i,
  input  logic [7:0]        in_char_i,
  input  logic              in_eoi_i,
  output logic              in_ready_o,
  input  logic              full_i,
  output logic              push_o,
  output ffp_bundle_t       bundle_o
);

  typedef enum logic [2:0] {
    PH_SEEK    = 3'd0,
    PH_NAME    = 3'd1,
    PH_COMMENT = 3'd2,
    PH_SEQ     = 3'd3,
    PH_PLUS    = 3'd4,
    PH_QUAL    = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        line_start_q, line_start_d;
  logic        held_cr_q, held_cr_d;
  logic [1:0]  det_fmt_q, det_fmt_d;
  logic        rec_open_q, rec_open_d;

  logic        accept;
  logic [1:0]  fmt;
  logic [2:0]  body_kind;
  logic [7:0]  term_char;
  logic        closed_now;
  ffp_bundle_t bnd;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  // Fixed format wins; otherwise use the format of the record in progress
  assign fmt = (fmt_mode_i == FmtFasta || fmt_mode_i == FmtFastq) ? fmt_mode_i : det_fmt_q;

  // Classify the byte and collect its results
  always_comb begin
    phase_d      = phase_q;
    line_start_d = line_start_q;
    held_cr_d    = held_cr_q;
    det_fmt_d    = det_fmt_q;
    rec_open_d   = rec_open_q;
    closed_now   = 1'b0;
    bnd          = '0;
    body_kind    = (phase_q == PH_QUAL) ? KindQual : KindSeq;
    term_char    = (phase_q == PH_QUAL) ? ChrAt : ((fmt == FmtFastq) ? ChrPlus : ChrGt);

    unique case (phase_q)
      PH_NAME, PH_COMMENT: begin
        if (in_char_i == ChrCr || (in_char_i == ChrTab && fmt == FmtFasta)) begin
          phase_d = phase_q;
        end else if (in_char_i == ChrLf) begin
          phase_d      = PH_SEQ;
          line_start_d = 1'b1;
          held_cr_d    = 1'b0;
        end else if (phase_q == PH_NAME && in_char_i == ChrSpace) begin
          phase_d = PH_COMMENT;
        end else begin
          bnd = ffp_put(bnd, in_char_i, (phase_q == PH_NAME) ? KindName : KindComment);
        end
      end
      PH_PLUS: begin
        if (in_char_i == ChrLf) begin
          phase_d      = PH_QUAL;
          line_start_d = 1'b1;
        end
      end
      PH_SEQ, PH_QUAL: begin
        if (line_start_q && in_char_i == term_char) begin
          line_start_d = 1'b0;
          held_cr_d    = 1'b0;
          if (phase_q == PH_SEQ && fmt == FmtFastq) begin
            phase_d = PH_PLUS;
          end else begin
            bnd        = ffp_put(bnd, 8'h00, KindEnd);
            phase_d    = PH_NAME;
            closed_now = 1'b1;
          end
        end else if (in_char_i == ChrLf) begin
          held_cr_d    = 1'b0;
          line_start_d = 1'b1;
        end else if (in_char_i == ChrCr) begin
          if (held_cr_q) begin
            bnd = ffp_put(bnd, ChrCr, body_kind);
          end
          held_cr_d    = 1'b1;
          line_start_d = 1'b0;
        end else begin
          if (held_cr_q) begin
            bnd = ffp_put(bnd, ChrCr, body_kind);
          end
          held_cr_d    = 1'b0;
          bnd          = ffp_put(bnd, in_char_i, body_kind);
          line_start_d = 1'b0;
        end
      end
      default: begin
        // Seeking, and any unused phase code
        phase_d = PH_SEEK;
        if (in_char_i == ChrGt && fmt != FmtFastq) begin
          det_fmt_d  = FmtFasta;
          phase_d    = PH_NAME;
          rec_open_d = 1'b1;
        end else if (in_char_i == ChrAt && fmt != FmtFasta) begin
          det_fmt_d  = FmtFastq;
          phase_d    = PH_NAME;
          rec_open_d = 1'b1;
        end
      end
    endcase

    // Close the open record at end of input and return to the reset state
    if (in_eoi_i) begin
      if (rec_open_d && !closed_now) begin
        if (held_cr_d) begin
          bnd = ffp_put(bnd, ChrCr, (phase_d == PH_QUAL) ? KindQual : KindSeq);
        end
        bnd = ffp_put(bnd, 8'h00, KindEnd);
      end
      phase_d      = PH_SEEK;
      line_start_d = 1'b1;
      held_cr_d    = 1'b0;
      det_fmt_d    = FmtUnknown;
      rec_open_d   = 1'b0;
    end
  end

  assign push_o   = accept && (bnd.count != 2'd0);
  assign bundle_o = bnd;

  // Advance the parse state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_SEEK;
      line_start_q <= 1'b1;
      held_cr_q    <= 1'b0;
      det_fmt_q    <= FmtUnknown;
      rec_open_q   <= 1'b0;
    end else if (accept) begin
      phase_q      <= phase_d;
      line_start_q <= line_start_d;
      held_cr_q    <= held_cr_d;
      det_fmt_q    <= det_fmt_d;
      rec_open_q   <= rec_open_d;
    end
  end

endmodule

// ===== sv/ffp_queue.sv =====
// Bundle queue between the front end and the output serialiser.
`include "fasta_fastq_record_parser_assert.svh"
module ffp_queue import ffp_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  ffp_bundle_t push_data_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        empty_o,
  output ffp_bundle_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ffp_bundle_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Store pushed bundles
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  `FFP_ASSERT(a_no_overflow, !(push_i && full_o), "bundle pushed into a full queue")
  `FFP_ASSERT(a_no_underflow, !(pop_i && empty_o), "bundle popped from an empty queue")
  `FFP_ASSERT(a_head_nonempty, empty_o || (head_o.count != 2'd0), "queued bundle without results")

endmodule

// ===== sv/ffp_back.sv =====
// Back end: walks the head bundle; one result per cycle while the receiver is ready.
`include "fasta_fastq_record_parser_assert.svh"
module ffp_back import ffp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  ffp_bundle_t head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_char_o,
  output logic [2:0]  out_kind_o,
  output logic        out_last_o
);

  logic [1:0] idx_q, idx_d;
  logic       fire;

  assign out_valid_o = !empty_i;
  assign out_char_o  = head_i.chars[idx_q];
  assign out_kind_o  = head_i.kinds[idx_q];
  assign out_last_o  = (idx_q == head_i.count - 2'd1);
  assign fire        = out_valid_o && out_ready_i;
  assign pop_o       = fire && out_last_o;

  // Step through the bundle; rewind once its last result is taken
  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = out_last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

  `FFP_ASSERT(a_idx_in_range, !out_valid_o || (idx_q < head_i.count), "slot beyond bundle")
  `FFP_ASSERT_IMP(a_step_on, fire && !out_last_o, idx_q == $past(idx_q) + 2'd1,
                  "slot did not advance within bundle")

endmodule

// ===== bench/fasta_fastq_record_parser_test.sv =====
// Self-checking testbench for the FASTA / FASTQ record parser.
module fasta_fastq_record_parser_test import ffp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Format register settings
  localparam logic [1:0] ModeAuto  = 2'd0;
  localparam logic [1:0] ModeFasta = 2'd1;
  localparam logic [1:0] ModeFastq = 2'd2;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned QuietLimit   = 1000;
  localparam int unsigned TotalBytes   = 120;

  typedef enum logic [2:0] {
    PhSeek, PhName, PhComment, PhSeq, PhPlus, PhQual
  } phase_e;

  typedef enum logic [1:0] {
    RxFree, RxCoin, RxQuarter, RxLong
  } rx_style_e;

  // One tagged output byte
  typedef struct packed {
    logic [7:0] ch;
    logic [2:0] kind;
    logic       last;
  } tag_t;

  // Tracks the parse state and holds the tags still due from the block
  class record_tag_board;
    logic [1:0]  fmt_mode;
    phase_e      phase;
    bit          at_line_start;
    bit          cr_held;
    logic [1:0]  seen_fmt;
    bit          in_record;
    tag_t        due_tags[$];
    tag_t        fresh[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned records;

    function new();
      fmt_mode   = ModeAuto;
      mismatches = 0;
      checked    = 0;
      records    = 0;
      clear();
    endfunction

    function void clear();
      phase         = PhSeek;
      at_line_start = 1'b1;
      cr_held       = 1'b0;
      seen_fmt      = FmtUnknown;
      in_record     = 1'b0;
    endfunction

    function void emit(logic [7:0] ch, logic [2:0] kind);
      if (fresh.size() < MaxResults) fresh.push_back('{ch, kind, 1'b0});
    endfunction

    // Work out the tags caused by one accepted byte
    function void take_byte(logic [7:0] c, logic eoi);
      logic [1:0] fmt;
      logic [2:0] kind;
      logic [7:0] term;
      bit         closed;
      tag_t       t;
      fmt    = (fmt_mode == ModeFasta || fmt_mode == ModeFastq) ? fmt_mode : seen_fmt;
      closed = 1'b0;
      fresh.delete();
      case (phase)
        PhSeek: begin
          if (c == ChrGt && fmt != FmtFastq) begin
            seen_fmt  = FmtFasta;
            phase     = PhName;
            in_record = 1'b1;
          end else if (c == ChrAt && fmt != FmtFasta) begin
            seen_fmt  = FmtFastq;
            phase     = PhName;
            in_record = 1'b1;
          end
        end
        PhName, PhComment: begin
          // drop CR always, tab only in FASTA headers
          if (!(c == ChrCr || (c == ChrTab && fmt == FmtFasta))) begin
            if (c == ChrLf) begin
              phase         = PhSeq;
              at_line_start = 1'b1;
              cr_held       = 1'b0;
            end else if (phase == PhName && c == ChrSpace) begin
              phase = PhComment;
            end else begin
              emit(c, phase == PhName ? KindName : KindComment);
            end
          end
        end
        PhPlus: begin
          if (c == ChrLf) begin
            phase         = PhQual;
            at_line_start = 1'b1;
          end
        end
        default: begin
          kind = (phase == PhQual) ? KindQual : KindSeq;
          term = (phase == PhQual) ? ChrAt : (fmt == FmtFastq ? ChrPlus : ChrGt);
          if (at_line_start && c == term) begin
            at_line_start = 1'b0;
            cr_held       = 1'b0;
            if (phase == PhSeq && fmt == FmtFastq) begin
              phase = PhPlus;
            end else begin
              emit(8'h00, KindEnd);
              phase  = PhName;
              closed = 1'b1;
            end
          end else if (c == ChrLf) begin
            cr_held       = 1'b0;
            at_line_start = 1'b1;
          end else if (c == ChrCr) begin
            // a CR already held turns out not to precede LF
            if (cr_held) emit(ChrCr, kind);
            cr_held       = 1'b1;
            at_line_start = 1'b0;
          end else begin
            if (cr_held) emit(ChrCr, kind);
            cr_held       = 1'b0;
            at_line_start = 1'b0;
            emit(c, kind);
          end
        end
      endcase

      // Close the open record at end of stream and start afresh
      if (eoi) begin
        if (in_record && !closed) begin
          if (cr_held) emit(ChrCr, phase == PhQual ? KindQual : KindSeq);
          emit(8'h00, KindEnd);
        end
        clear();
      end

      if (fresh.size() != 0) begin
        t      = fresh.pop_back();
        t.last = 1'b1;
        fresh.push_back(t);
      end
      foreach (fresh[i]) due_tags.push_back(fresh[i]);
    endfunction

    // Compare one accepted result with the oldest tag due
    function void check_tag(logic [7:0] ch, logic [2:0] kind, logic last);
      tag_t want;
      if (due_tags.size() == 0) begin
        $error("unexpected result: out_char %02h field_kind %0d last_of_run %0b",
               ch, kind, last);
        mismatches++;
        return;
      end
      want = due_tags.pop_front();
      checked++;
      if (want.kind == KindEnd) records++;
      if (ch !== want.ch) begin
        $error("out_char: expected %02h, got %02h", want.ch, ch);
        mismatches++;
      end
      if (kind !== want.kind) begin
        $error("field_kind: expected %0d, got %0d", want.kind, kind);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0b, got %0b", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic [1:0] cfg_wdata_i   = 2'd0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic       m_axis_tlast;

  record_tag_board board = new();

  logic [7:0]  text[$];
  int unsigned burst_left   = 0;
  int unsigned bytes_sent   = 0;
  int unsigned settings     = 0;
  int unsigned quiet_cycles = 0;
  rx_style_e   rx_style     = RxFree;
  int unsigned rx_span      = 0;
  int unsigned rx_tick      = 0;

  fasta_fastq_record_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  // Receiver: switch between free running, coin toss, a quarter-rate pattern and long stalls
  always @(posedge clk_i) begin
    if (rx_span == 0) begin
      rx_style <= rx_style_e'($urandom_range(0, 3));
      rx_span  <= $urandom_range(16, 96);
    end else begin
      rx_span <= rx_span - 1;
    end
    rx_tick <= rx_tick + 1;
    case (rx_style)
      RxFree:    m_axis_tready <= 1'b1;
      RxCoin:    m_axis_tready <= 1'($urandom_range(0, 1));
      RxQuarter: m_axis_tready <= (rx_tick % 4 == 0);
      default:   m_axis_tready <= (rx_tick % 15 < 3);
    endcase
  end

  // Check every result item taken from the block
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_tag(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // Watchdog: end the run if no item moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: no item moved for %0d cycles", QuietLimit);
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one byte, idling between bursts, and hold it until taken
  task automatic send_byte(input logic [7:0] ch, input logic eoi);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= eoi;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.take_byte(ch, eoi);
    bytes_sent++;
  endtask

  task automatic send_text(input bit close);
    foreach (text[i]) send_byte(text[i], close && (i == text.size() - 1));
  endtask

  // Hold input until every tag due has come, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (board.due_tags.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_format(input logic [1:0] mode);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    board.fmt_mode = mode;
    settings++;
  endtask

  // Mostly bases, some arbitrary bytes and stray CRs
  function automatic logic [7:0] body_char();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 4) return "A";
    if (r < 8) return "C";
    if (r < 12) return "G";
    if (r < 16) return "T";
    if (r < 18) return 8'($urandom_range(0, 255));
    return ChrCr;
  endfunction

  function automatic void add_record(bit fastq);
    text.push_back(fastq ? ChrAt : ChrGt);
    repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(33, 126)));
    if ($urandom_range(0, 1) != 0) begin
      text.push_back(ChrSpace);
      repeat ($urandom_range(0, 5)) begin
        text.push_back(($urandom_range(0, 5) == 0) ? ChrTab : 8'($urandom_range(32, 126)));
      end
    end
    if ($urandom_range(0, 3) == 0) text.push_back(ChrCr);
    text.push_back(ChrLf);
    // sequence lines, blank ones included
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(0, 6)) text.push_back(body_char());
      if ($urandom_range(0, 3) == 0) text.push_back(ChrCr);
      text.push_back(ChrLf);
    end
    if (fastq) begin
      text.push_back(ChrPlus);
      repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(32, 126)));
      text.push_back(ChrLf);
      repeat ($urandom_range(1, 2)) begin
        repeat ($urandom_range(0, 5)) text.push_back(8'($urandom_range(33, 73)));
        if ($urandom_range(0, 3) == 0) text.push_back(ChrCr);
        text.push_back(ChrLf);
      end
    end
  endfunction

  // Noise, a few records, then an odd ending now and then
  function automatic void build_stream(logic [1:0] mode);
    bit fastq;
    fastq = (mode == ModeFastq) ? 1'b1 :
            (mode == ModeFasta) ? 1'b0 : 1'($urandom_range(0, 1));
    text.delete();
    repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(0, 255)));
    repeat ($urandom_range(1, 3)) add_record(fastq);
    case ($urandom_range(0, 5))
      0: text.push_back(fastq ? ChrAt : ChrGt);
      1: if (text[$] == ChrLf) void'(text.pop_back());
      2: text.push_back(ChrCr);
      default: ;
    endcase
  endfunction

  initial begin
    logic [1:0] mode;
    int unsigned phase_no;
    int unsigned streams;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: auto-detect a FASTA record with tab, space split, CRs, blank line
    write_format(ModeAuto);
    text = '{8'hFF, ChrGt, "n", ChrTab, "m", ChrSpace, "c", ChrCr, ChrLf,
             "A", ChrCr, "C", ChrCr, ChrLf, ChrLf, "G", ChrCr};
    send_text(1'b1);

    // Directed: fixed FASTQ, empty sequence, plus line, terminator as last byte
    write_format(ModeFastq);
    text = '{ChrAt, "q", ChrLf, ChrPlus, ChrLf, "I", 8'h00, ChrLf, ChrAt};
    send_text(1'b1);

    // Random streams over rotating format settings
    phase_no = 0;
    while (bytes_sent < TotalBytes) begin
      case (phase_no % 3)
        0:       mode = ModeFasta;
        1:       mode = ModeAuto;
        default: mode = ModeFastq;
      endcase
      write_format(mode);
      streams = $urandom_range(1, 2);
      for (int s = 0; s < streams; s++) begin
        build_stream(mode);
        // now and then leave the stream open across a format change
        send_text(!(s == streams - 1 && $urandom_range(0, 3) == 0));
      end
      phase_no++;
    end

    drain();
    $display("Covered %0d input bytes over %0d format settings (auto, FASTA, FASTQ)",
             bytes_sent, settings);
    $display("Checked %0d tagged results, %0d of them record ends",
             board.checked, board.records);
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== fasta_fastq_record_parser.f =====
+incdir+sv
sv/ffp_pkg.sv
sv/ffp_front.sv
sv/ffp_queue.sv
sv/ffp_back.sv
sv/fasta_fastq_record_parser.sv
bench/fasta_fastq_record_parser_test.sv
